// ----- design/pcc_pkg.sv -----
package pcc_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_IN_WIDTH  = 24;
  localparam int ANGLE_OUT_WIDTH = 16;

  // Datapath widths: the gain is a positive 24-bit fraction, so a product needs
  // COORD_WIDTH + 25 bits, and the CORDIC growth adds one more bit of headroom.
  localparam int PROD_WIDTH = COORD_WIDTH + 25;
  localparam int DATA_WIDTH = COORD_WIDTH + 26;
  localparam int Z_WIDTH    = 33;

  localparam int PI_Q16        = 205887;
  localparam int TWO_PI_Q16    = 411775;
  localparam int WRAP_TURNS    = 20;
  localparam int WRAP_OFFSET   = PI_Q16 + WRAP_TURNS * TWO_PI_Q16;
  localparam int PI_Q28        = 843314857;
  localparam int HALF_PI_Q28   = 421657428;
  localparam int GAIN_Q24      = 10188014;
  localparam int ANGLE_OUT_MAX = 25736;

  typedef enum logic {
    OP_P2C = 1'b0,
    OP_C2P = 1'b1
  } op_e;

  typedef logic signed [COORD_WIDTH-1:0]     coord_t;
  typedef logic        [COORD_WIDTH-1:0]     radius_t;
  typedef logic signed [ANGLE_IN_WIDTH-1:0]  angle_in_t;
  typedef logic signed [ANGLE_OUT_WIDTH-1:0] angle_out_t;
  typedef logic signed [Z_WIDTH-1:0]         zval_t;

  // Arctangent of 2^-i in Q4.28.
  function automatic zval_t atan_step(input int i);
    zval_t a;
    case (i)
      0: a = Z_WIDTH'(210828714);
      1: a = Z_WIDTH'(124459457);
      2: a = Z_WIDTH'(65760959);
      3: a = Z_WIDTH'(33381290);
      4: a = Z_WIDTH'(16755422);
      5: a = Z_WIDTH'(8385879);
      6: a = Z_WIDTH'(4193963);
      7: a = Z_WIDTH'(2097109);
      8: a = Z_WIDTH'(1048571);
      9: a = Z_WIDTH'(524287);
      default: a = (i <= 28) ? (Z_WIDTH'(1) << (28 - i)) : '0;
    endcase
    return a;
  endfunction

endpackage

// ----- design/pcc_in_if.sv -----
interface pcc_in_if;
  import pcc_pkg::*;

  logic      valid;
  logic      ready;
  op_e       op;
  coord_t    radius_in;
  angle_in_t angle_in;
  coord_t    x_in;
  coord_t    y_in;

  modport source (output valid, op, radius_in, angle_in, x_in, y_in, input ready);
  modport sink (input valid, op, radius_in, angle_in, x_in, y_in, output ready);
endinterface

// ----- design/pcc_out_if.sv -----
interface pcc_out_if;
  import pcc_pkg::*;

  logic       valid;
  logic       ready;
  coord_t     x_out;
  coord_t     y_out;
  radius_t    radius_out;
  angle_out_t angle_out;

  modport source (output valid, x_out, y_out, radius_out, angle_out, input ready);
  modport sink (input valid, x_out, y_out, radius_out, angle_out, output ready);
endinterface

// ----- design/polar_cartesian_converter_core.sv -----
// Channel | Role   | Beat
// in_i    | sink   | op, radius_in, angle_in, x_in, y_in
// out_o   | source | x_out, y_out, radius_out, angle_out
//
// A beat is accepted every cycle unless the output register holds a beat that is not being taken.
// The pipeline is made of the two angle-wrap stages, the setup stage, one CORDIC
// micro-rotation per stage and the rounding output register.
// Reset clears only the valid bits; the pipeline is empty afterwards.
// All stages advance together whenever the output register is empty or being taken.
module polar_cartesian_converter_core (
  input  logic clk_i,
  input  logic rst_ni,
  pcc_in_if.sink    in_i,
  pcc_out_if.source out_o
);
  import pcc_pkg::*;

  localparam int CW        = COORD_WIDTH;
  localparam int N         = CORDIC_STAGES;
  localparam int PW        = PROD_WIDTH;
  localparam int DW        = DATA_WIDTH;
  localparam int ZW        = Z_WIDTH;
  localparam int UWidth    = 25;
  localparam int Rem1Width = 22;
  localparam int Rem2Width = 19;
  localparam int ZwWidth   = 20;
  localparam int FracShift = 12;

  localparam logic signed [PW-1:0] GainS    = PW'(GAIN_Q24);
  localparam zval_t                PiZ      = ZW'(PI_Q28);
  localparam zval_t                HalfPiZ  = ZW'(HALF_PI_Q28);
  localparam zval_t                AngMax   = ZW'(ANGLE_OUT_MAX);
  localparam zval_t                RoundZ   = ZW'(1) << 14;
  localparam logic signed [DW-1:0] RoundXy  = DW'(1) << 23;
  localparam logic signed [DW-1:0] CoordMax = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [DW-1:0] CoordMin = ~CoordMax;
  localparam logic signed [DW-1:0] RadMax   = {{(DW-CW){1'b0}}, {CW{1'b1}}};

  logic en;

  logic                    s1_valid_q;
  op_e                     s1_op_q;
  logic signed [PW-1:0]    s1_px_q, s1_py_q, px_d, py_d;
  logic [Rem1Width-1:0]    s1_rem_q, rem1_d;
  logic [UWidth-1:0]       u;
  coord_t                  mult_a, mult_b;

  logic                    s2_valid_q;
  op_e                     s2_op_q;
  logic signed [PW-1:0]    s2_px_q, s2_py_q;
  logic signed [ZwWidth-1:0] s2_zw_q, zw_d;
  logic [Rem1Width-1:0]    v;

  logic                    c_valid_q [0:N];
  op_e                     c_op_q    [0:N];
  logic                    c_zero_q  [0:N];
  logic signed [DW-1:0]    c_x_q     [0:N];
  logic signed [DW-1:0]    c_y_q     [0:N];
  zval_t                   c_z_q     [0:N];

  logic signed [DW-1:0]    x0, y0, x_set, y_set;
  zval_t                   zf, z_set;
  logic                    zero_set;

  logic signed [DW-1:0]    xr, yr, rr, xc, yc, rc;
  zval_t                   zr, zc;

  logic                    out_valid_q;
  coord_t                  x_out_q, y_out_q;
  radius_t                 radius_out_q;
  angle_out_t              angle_out_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // Stage 1: gain multiply and the coarse part of the angle wrap.
  always_comb begin
    mult_a = (in_i.op == OP_C2P) ? in_i.x_in : in_i.radius_in;
    mult_b = (in_i.op == OP_C2P) ? in_i.y_in : '0;
    px_d   = PW'(mult_a) * GainS;
    py_d   = PW'(mult_b) * GainS;
    u = UWidth'(26'(in_i.angle_in) + 26'(WRAP_OFFSET));
    for (int k = 5; k >= 3; k--) begin
      if (u >= (UWidth'(TWO_PI_Q16) << k)) begin
        u = u - (UWidth'(TWO_PI_Q16) << k);
      end
    end
    rem1_d = u[Rem1Width-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q  <= in_i.op;
      s1_px_q  <= px_d;
      s1_py_q  <= py_d;
      s1_rem_q <= rem1_d;
    end
  end

  // Stage 2: fine part of the angle wrap.
  always_comb begin
    v = s1_rem_q;
    for (int k = 2; k >= 0; k--) begin
      if (v >= (Rem1Width'(TWO_PI_Q16) << k)) begin
        v = v - (Rem1Width'(TWO_PI_Q16) << k);
      end
    end
    zw_d = $signed({1'b0, v[Rem2Width-1:0]}) - ZwWidth'(PI_Q16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q <= s1_op_q;
      s2_px_q <= s1_px_q;
      s2_py_q <= s1_py_q;
      s2_zw_q <= zw_d;
    end
  end

  // Stage 3: quadrant fold and start vector.
  always_comb begin
    x0       = DW'(s2_px_q);
    y0       = DW'(s2_py_q);
    zf       = ZW'(s2_zw_q) <<< FracShift;
    x_set    = x0;
    y_set    = y0;
    z_set    = '0;
    zero_set = 1'b0;
    if (s2_op_q == OP_P2C) begin
      y_set = '0;
      z_set = zf;
      if (zf > HalfPiZ) begin
        z_set = zf - PiZ;
        x_set = -x0;
      end else if (zf < -HalfPiZ) begin
        z_set = zf + PiZ;
        x_set = -x0;
      end
    end else begin
      zero_set = (s2_px_q == '0) && (s2_py_q == '0);
      if (s2_px_q < 0) begin
        z_set = (s2_py_q >= 0) ? PiZ : -PiZ;
        x_set = -x0;
        y_set = -y0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q[0] <= 1'b0;
    end else if (en) begin
      c_valid_q[0] <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_op_q[0]   <= s2_op_q;
      c_zero_q[0] <= zero_set;
      c_x_q[0]    <= x_set;
      c_y_q[0]    <= y_set;
      c_z_q[0]    <= z_set;
    end
  end

  // One micro-rotation per stage; shifts are arithmetic, so they round down.
  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [DW-1:0] xs, ys;
    logic                 ccw;

    assign xs  = c_x_q[i] >>> i;
    assign ys  = c_y_q[i] >>> i;
    assign ccw = (c_op_q[i] == OP_C2P) ? c_y_q[i][DW-1] : !c_z_q[i][ZW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_valid_q[i+1] <= 1'b0;
      end else if (en) begin
        c_valid_q[i+1] <= c_valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        c_op_q[i+1]   <= c_op_q[i];
        c_zero_q[i+1] <= c_zero_q[i];
        if (ccw) begin
          c_x_q[i+1] <= c_x_q[i] - ys;
          c_y_q[i+1] <= c_y_q[i] + xs;
          c_z_q[i+1] <= c_z_q[i] - atan_step(i);
        end else begin
          c_x_q[i+1] <= c_x_q[i] + ys;
          c_y_q[i+1] <= c_y_q[i] - xs;
          c_z_q[i+1] <= c_z_q[i] + atan_step(i);
        end
      end
    end
  end

  // Output stage: round half up, saturate, and zero the fields the operation leaves unused.
  always_comb begin
    xr = (c_x_q[N] + RoundXy) >>> 24;
    yr = (c_y_q[N] + RoundXy) >>> 24;
    rr = xr;
    zr = (c_z_q[N] + RoundZ) >>> 15;
    xc = (xr > CoordMax) ? CoordMax : ((xr < CoordMin) ? CoordMin : xr);
    yc = (yr > CoordMax) ? CoordMax : ((yr < CoordMin) ? CoordMin : yr);
    rc = (rr > RadMax) ? RadMax : ((rr < 0) ? '0 : rr);
    zc = (zr > AngMax) ? AngMax : ((zr < -AngMax) ? -AngMax : zr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_valid_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (c_op_q[N] == OP_P2C) begin
        x_out_q      <= xc[CW-1:0];
        y_out_q      <= yc[CW-1:0];
        radius_out_q <= '0;
        angle_out_q  <= '0;
      end else begin
        x_out_q      <= '0;
        y_out_q      <= '0;
        radius_out_q <= c_zero_q[N] ? '0 : rc[CW-1:0];
        angle_out_q  <= c_zero_q[N] ? '0 : zc[ANGLE_OUT_WIDTH-1:0];
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.x_out      = x_out_q;
  assign out_o.y_out      = y_out_q;
  assign out_o.radius_out = radius_out_q;
  assign out_o.angle_out  = angle_out_q;

  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && (s2_op_q == OP_P2C) |->
      (s2_zw_q >= -ZwWidth'(PI_Q16)) && (s2_zw_q <= ZwWidth'(PI_Q16)))
    else $error("Wrapped angle is outside one turn around zero.");

  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q[0] && (c_op_q[0] == OP_P2C) |->
      (c_z_q[0] <= HalfPiZ) && (c_z_q[0] >= -HalfPiZ))
    else $error("Folded angle is outside the right half plane.");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.angle_out <= ANGLE_OUT_WIDTH'(ANGLE_OUT_MAX)) &&
      (out_o.angle_out >= -ANGLE_OUT_WIDTH'(ANGLE_OUT_MAX)))
    else $error("Output angle exceeds pi.");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && ((out_o.radius_out != '0) || (out_o.angle_out != '0)) |->
      (out_o.x_out == '0) && (out_o.y_out == '0))
    else $error("Polar result carries nonzero Cartesian fields.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(c_valid_q[N]) && $stable(s1_valid_q))
    else $error("Pipeline moved during a stall.");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import pcc_pkg::*;

  localparam int  STALL_LIMIT = 2000;
  localparam int  DRAIN_CYCLES = CORDIC_STAGES + 12;
  localparam int  RANDOM_ITEMS = 1100;
  localparam int  PHASES = 4;
  localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;
  localparam longint RADIUS_MAX = (longint'(1) << COORD_WIDTH) - 1;
  localparam longint ARCTAN_Q28 [10] = '{
    210828714, 124459457, 65760959, 33381290, 16755422,
    8385879, 4193963, 2097109, 1048571, 524287
  };

  typedef struct packed {
    op_e       op;
    coord_t    radius_in;
    angle_in_t angle_in;
    coord_t    x_in;
    coord_t    y_in;
  } conv_req_t;

  typedef struct packed {
    coord_t     x_out;
    coord_t     y_out;
    radius_t    radius_out;
    angle_out_t angle_out;
  } conv_rsp_t;

  class conversion_scoreboard;
    conv_rsp_t   pending_q[$];
    int unsigned mismatches;
    int unsigned n_p2c;
    int unsigned n_c2p;

    function longint arctan_q28(int i);
      if (i < 10) return ARCTAN_Q28[i];
      if (i <= 28) return longint'(1) << (28 - i);
      return 0;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function longint round_q24(longint v);
      return (v + (longint'(1) << 23)) >>> 24;
    endfunction

    function conv_rsp_t convert(conv_req_t req);
      conv_rsp_t rsp;
      longint    ang;
      longint    xv;
      longint    yv;
      longint    zv;
      longint    xs;
      longint    ys;
      longint    t;
      rsp = '0;
      if (req.op == OP_P2C) begin
        ang = longint'(req.angle_in);
        while (ang > PI_Q16) ang -= TWO_PI_Q16;
        while (ang <= PI_Q16 - TWO_PI_Q16) ang += TWO_PI_Q16;
        zv = ang * 4096;
        xv = longint'(req.radius_in) * GAIN_Q24;
        yv = 0;
        if (zv > HALF_PI_Q28) begin
          zv -= PI_Q28;
          xv = -xv;
        end else if (zv < -HALF_PI_Q28) begin
          zv += PI_Q28;
          xv = -xv;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
          xs = xv >>> i;
          ys = yv >>> i;
          if (zv >= 0) begin
            t = xv - ys;
            yv = yv + xs;
            zv -= arctan_q28(i);
          end else begin
            t = xv + ys;
            yv = yv - xs;
            zv += arctan_q28(i);
          end
          xv = t;
        end
        rsp.x_out = coord_t'(clip(round_q24(xv), COORD_MIN, COORD_MAX));
        rsp.y_out = coord_t'(clip(round_q24(yv), COORD_MIN, COORD_MAX));
      end else begin
        // The zero vector has no direction; both fields stay zero.
        if (req.x_in == 0 && req.y_in == 0) return rsp;
        xv = longint'(req.x_in) * GAIN_Q24;
        yv = longint'(req.y_in) * GAIN_Q24;
        zv = 0;
        if (req.x_in < 0) begin
          zv = (req.y_in >= 0) ? PI_Q28 : -longint'(PI_Q28);
          xv = -xv;
          yv = -yv;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
          xs = xv >>> i;
          ys = yv >>> i;
          if (yv >= 0) begin
            t = xv + ys;
            yv = yv - xs;
            zv += arctan_q28(i);
          end else begin
            t = xv - ys;
            yv = yv + xs;
            zv -= arctan_q28(i);
          end
          xv = t;
        end
        rsp.radius_out = radius_t'(clip(round_q24(xv), 0, RADIUS_MAX));
        rsp.angle_out = angle_out_t'(clip((zv + (longint'(1) << 14)) >>> 15,
                                          -ANGLE_OUT_MAX, ANGLE_OUT_MAX));
      end
      return rsp;
    endfunction

    function void note_input(conv_req_t req);
      pending_q.push_back(convert(req));
      if (req.op == OP_P2C) n_p2c++;
      else n_c2p++;
    endfunction

    function void check_result(conv_rsp_t act);
      conv_rsp_t exp_rsp;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d r=%0d a=%0d", $time,
                 act.x_out, act.y_out, act.radius_out, act.angle_out);
        mismatches++;
        return;
      end
      exp_rsp = pending_q.pop_front();
      if (act.x_out !== exp_rsp.x_out || act.y_out !== exp_rsp.y_out ||
          act.radius_out !== exp_rsp.radius_out || act.angle_out !== exp_rsp.angle_out) begin
        $display("%0t: expected x=%0d y=%0d r=%0d a=%0d, got x=%0d y=%0d r=%0d a=%0d",
                 $time, exp_rsp.x_out, exp_rsp.y_out, exp_rsp.radius_out,
                 exp_rsp.angle_out, act.x_out, act.y_out, act.radius_out, act.angle_out);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   in_burst;
  bit   out_burst;
  int   stall_cycles;

  conversion_scoreboard sb;

  pcc_in_if  in_if ();
  pcc_out_if out_if ();

  polar_cartesian_converter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : int'($urandom_range(0, 12));
  endfunction

  function automatic conv_req_t mk_p2c(longint rad, longint ang);
    conv_req_t req;
    req.op = OP_P2C;
    req.radius_in = coord_t'(rad);
    req.angle_in = angle_in_t'(ang);
    req.x_in = coord_t'($urandom);
    req.y_in = coord_t'($urandom);
    return req;
  endfunction

  function automatic conv_req_t mk_c2p(longint xv, longint yv);
    conv_req_t req;
    req.op = OP_C2P;
    req.radius_in = coord_t'($urandom);
    req.angle_in = angle_in_t'($urandom);
    req.x_in = coord_t'(xv);
    req.y_in = coord_t'(yv);
    return req;
  endfunction

  function automatic longint rand_coord();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      1: return longint'($urandom_range(0, 64)) - 32;
      default: return longint'(coord_t'($urandom));
    endcase
  endfunction

  function automatic longint rand_angle();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 8388607 : -8388608;
      1: return (longint'($urandom_range(0, 80)) - 40) * PI_Q16 +
                longint'($urandom_range(0, 6)) - 3;
      2: return longint'($urandom_range(0, 2 * PI_Q16)) - PI_Q16;
      default: return longint'(angle_in_t'($urandom));
    endcase
  endfunction

  function automatic conv_req_t rand_req();
    if ($urandom_range(0, 1)) return mk_c2p(rand_coord(), rand_coord());
    return mk_p2c(rand_coord(), rand_angle());
  endfunction

  task automatic send_beat(conv_req_t req, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= req.op;
    in_if.radius_in <= req.radius_in;
    in_if.angle_in <= req.angle_in;
    in_if.x_in <= req.x_in;
    in_if.y_in <= req.y_in;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(req);
    @(negedge clk_i);
  endtask

  task automatic take_beat(int gap);
    conv_rsp_t act;
    if (gap > 0) begin
      out_if.ready <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    out_if.ready <= 1'b1;
    @(posedge clk_i);
    while (!out_if.valid) @(posedge clk_i);
    act.x_out = out_if.x_out;
    act.y_out = out_if.y_out;
    act.radius_out = out_if.radius_out;
    act.angle_out = out_if.angle_out;
    sb.check_result(act);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_directed();
    conv_req_t dir_q[$];
    dir_q.push_back(mk_p2c(COORD_MAX, 0));
    dir_q.push_back(mk_p2c(COORD_MIN, 0));
    dir_q.push_back(mk_p2c(0, 12345));
    dir_q.push_back(mk_p2c(COORD_MAX, PI_Q16));
    dir_q.push_back(mk_p2c(COORD_MAX, PI_Q16 + 1));
    dir_q.push_back(mk_p2c(COORD_MIN, PI_Q16 - TWO_PI_Q16));
    dir_q.push_back(mk_p2c(COORD_MAX, PI_Q16 - TWO_PI_Q16 + 1));
    dir_q.push_back(mk_p2c(20000, 8388607));
    dir_q.push_back(mk_p2c(-20000, -8388608));
    dir_q.push_back(mk_p2c(30000, 102943));
    dir_q.push_back(mk_p2c(30000, 102944));
    dir_q.push_back(mk_p2c(30000, -102944));
    dir_q.push_back(mk_p2c(COORD_MIN, -102943));
    dir_q.push_back(mk_c2p(0, 0));
    dir_q.push_back(mk_c2p(COORD_MAX, COORD_MAX));
    dir_q.push_back(mk_c2p(COORD_MIN, COORD_MIN));
    dir_q.push_back(mk_c2p(COORD_MIN, 0));
    dir_q.push_back(mk_c2p(-1, 0));
    dir_q.push_back(mk_c2p(-1, -1));
    dir_q.push_back(mk_c2p(0, 1));
    dir_q.push_back(mk_c2p(0, -1));
    dir_q.push_back(mk_c2p(1, 0));
    dir_q.push_back(mk_c2p(COORD_MAX, 0));
    dir_q.push_back(mk_c2p(COORD_MIN, COORD_MAX));
    foreach (dir_q[i]) send_beat(dir_q[i], draw_gap(in_burst));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("polar_cartesian_converter_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever take_beat(draw_gap(out_burst));
  end

  initial begin
    sb = new();
    stall_cycles = 0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_P2C;
    in_if.radius_in = '0;
    in_if.angle_in = '0;
    in_if.x_in = '0;
    in_if.y_in = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_directed();
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      in_burst = phase[0];
      out_burst = phase[1];
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        send_beat(rand_req(), draw_gap(in_burst));
      end
      if (phase == 0 || phase == 2) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Converted %0d polar-to-Cartesian and %0d Cartesian-to-polar beats,",
             sb.n_p2c, sb.n_c2p);
    $display("with angle wraps, quadrant folds, saturation and the zero vector.");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("polar_cartesian_converter_core: match");
    end else begin
      $display("polar_cartesian_converter_core: mismatch");
    end
    $finish;
  end

endmodule
